[src/annexb_nal_splitter_assert.svh]
// Assertion macros used by the splitter back end (ans_back).
`ifndef ANNEXB_NAL_SPLITTER_ASSERT_SVH
`define ANNEXB_NAL_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define ANS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ans assertion failed");

// Next-cycle implication.
`define ANS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ans assertion failed");

`endif

[src/ans_pkg.sv]
`default_nettype none

package ans_pkg;

   localparam int POS_CAP    = 4194304;
   localparam int OFF_W      = 22;
   localparam int SIZE_W     = 23;
   localparam int TS_W       = 64;
   localparam int CMD_DEPTH  = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [SIZE_W-1:0] TOTAL_MAX = 23'h7FFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODEC_SELECT = 2'd1;

   // H.264 types
   localparam logic [5:0] AVC_TYPE_MASK = 6'h1F;
   localparam logic [5:0] AVC_IDR       = 6'h05;
   localparam logic [5:0] AVC_SEI       = 6'h06;
   localparam logic [5:0] AVC_SPS       = 6'h07;
   localparam logic [5:0] AVC_PPS       = 6'h08;
   // H.265 types
   localparam logic [5:0] HEVC_TYPE_MASK = 6'h3F;
   localparam logic [5:0] HEVC_KEY_LO    = 6'h10;
   localparam logic [5:0] HEVC_KEY_HI    = 6'h15;
   localparam logic [5:0] HEVC_VPS       = 6'h20;
   localparam logic [5:0] HEVC_SPS       = 6'h21;
   localparam logic [5:0] HEVC_PPS       = 6'h22;
   localparam logic [5:0] HEVC_SEI_PRE   = 6'h27;
   localparam logic [5:0] HEVC_SEI_SUF   = 6'h28;
   localparam logic [5:0] HEVC_SLICE_HI  = 6'h09;

   typedef enum logic [2:0] {
      CLS_VPS   = 3'd0,
      CLS_SPS   = 3'd1,
      CLS_PPS   = 3'd2,
      CLS_SEI   = 3'd3,
      CLS_SLICE = 3'd4,
      CLS_DROP  = 3'd5
   } nal_class_type;

   typedef enum logic {
      BK_DESC = 1'b0,
      BK_SUMM = 1'b1
   } back_state_type;

   typedef struct packed {
      logic video_enable;
      logic codec_select;
   } cfg_type;

   // One queued event: an optional NAL close and an optional unit summary.
   typedef struct packed {
      logic              close_valid;
      logic [5:0]        hdr_type;
      logic [OFF_W-1:0]  offset;
      logic [OFF_W-1:0]  length;
      logic [OFF_W-1:0]  trim_length;
      logic              trim_ok;
      logic              summary_valid;
      logic [TS_W-1:0]   timestamp;
   } cmd_type;

endpackage

`default_nettype wire

[src/ans_if.sv]
`default_nettype none

interface ans_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        end_of_unit;
   logic [63:0] timestamp;

   modport source (output valid, data_byte, end_of_unit, timestamp, input ready);
   modport sink (input valid, data_byte, end_of_unit, timestamp, output ready);
endinterface

interface ans_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [5:0]  nal_type;
   logic [2:0]  nal_class;
   logic [21:0] nal_offset;
   logic [21:0] nal_length;
   logic        is_key;
   logic [22:0] unit_size;
   logic        unit_written;
   logic [63:0] decode_time;
   logic        became_ready;
   logic        last_result;

   modport source (output valid, result_kind, nal_type, nal_class, nal_offset,
                   nal_length, is_key, unit_size, unit_written, decode_time,
                   became_ready, last_result, input ready);
   modport sink (input valid, result_kind, nal_type, nal_class, nal_offset,
                 nal_length, is_key, unit_size, unit_written, decode_time,
                 became_ready, last_result, output ready);
endinterface

interface ans_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/ans_front.sv]
`default_nettype none

module ans_front #(
   parameter int LIMIT = 4194304,
   parameter int POS_W = 23
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ans_pkg::cfg_type cfg,
   ans_req_if.sink               req,
   input  wire logic             q_full,
   output      logic             q_push,
   output      ans_pkg::cmd_type q_data
);

   logic [1:0]       zr_ff, zr_in;
   logic             in_nal_ff, in_nal_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] begin_ff, begin_in;
   logic [POS_W-1:0] lnz_ff, lnz_in;
   logic [5:0]       hdr_ff, hdr_in;

   logic             fire, accepted;
   logic [7:0]       b;
   logic [POS_W-1:0] pos_inc;
   logic [5:0]       pay_hdr;
   logic [POS_W-1:0] pay_lnz;
   logic [1:0]       pay_zr;
   logic             close_try, close_valid, summary;
   logic [POS_W-1:0] close_end, close_lnz;
   logic [5:0]       close_hdr;

   assign req.ready = !q_full;
   assign fire      = req.valid && !q_full;
   assign b         = req.data_byte;
   assign accepted  = pos_ff < POS_W'(LIMIT);
   assign pos_inc   = pos_ff + POS_W'(1);

   // payload byte update
   always_comb begin
      pay_hdr = hdr_ff;
      if (pos_ff == begin_ff) begin
         pay_hdr = cfg.codec_select ? b[6:1] : {1'b0, b[4:0]};
      end
      if (b != 8'd0) begin
         pay_lnz = pos_ff;
         pay_zr  = 2'd0;
      end else begin
         pay_lnz = lnz_ff;
         pay_zr  = (zr_ff == 2'd3) ? zr_ff : zr_ff + 2'd1;
      end
   end

   always_comb begin
      zr_in     = zr_ff;
      in_nal_in = in_nal_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      lnz_in    = lnz_ff;
      hdr_in    = hdr_ff;
      close_try = 1'b0;
      summary   = 1'b0;
      close_end = pos_ff - POS_W'(2);
      close_lnz = lnz_ff;
      close_hdr = hdr_ff;
      if (fire) begin
         if (!req.end_of_unit) begin
            if (accepted) begin
               pos_in = pos_inc;
               if (in_nal_ff) begin
                  if (zr_ff >= 2'd2 && b <= 8'd1) begin
                     close_try = 1'b1;
                     if (b == 8'd1) begin
                        begin_in = pos_inc;
                        zr_in    = 2'd0;
                     end else begin
                        in_nal_in = 1'b0;
                        zr_in     = 2'd2;
                     end
                  end else begin
                     hdr_in = pay_hdr;
                     lnz_in = pay_lnz;
                     zr_in  = pay_zr;
                  end
               end else if (b == 8'd1 && zr_ff >= 2'd2) begin
                  in_nal_in = 1'b1;
                  begin_in  = pos_inc;
                  zr_in     = 2'd0;
               end else if (b == 8'd0) begin
                  zr_in = (zr_ff == 2'd3) ? zr_ff : zr_ff + 2'd1;
               end else begin
                  zr_in = 2'd0;
               end
            end
         end else begin
            summary = 1'b1;
            if (in_nal_ff) begin
               close_try = 1'b1;
               if (accepted) begin
                  close_hdr = pay_hdr;
                  close_lnz = pay_lnz;
                  close_end = pos_inc;
                  hdr_in    = pay_hdr;
               end else begin
                  close_end = pos_ff;
               end
            end
            zr_in     = 2'd0;
            in_nal_in = 1'b0;
            pos_in    = '0;
            begin_in  = '0;
            lnz_in    = '0;
         end
      end
   end

   // an empty NAL gives no descriptor
   assign close_valid = close_try && (close_end > begin_ff);
   assign q_push      = fire && (close_valid || summary);

   always_comb begin
      q_data               = '0;
      q_data.close_valid   = close_valid;
      q_data.hdr_type      = close_hdr;
      q_data.offset        = ans_pkg::OFF_W'(begin_ff);
      q_data.length        = ans_pkg::OFF_W'(close_end - begin_ff);
      q_data.trim_length   = ans_pkg::OFF_W'(close_lnz - begin_ff + POS_W'(1));
      q_data.trim_ok       = (close_lnz >= begin_ff) && (close_lnz < close_end);
      q_data.summary_valid = summary;
      q_data.timestamp     = req.timestamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zr_ff     <= '0;
         in_nal_ff <= 1'b0;
         pos_ff    <= '0;
         begin_ff  <= '0;
         lnz_ff    <= '0;
         hdr_ff    <= '0;
      end else begin
         zr_ff     <= zr_in;
         in_nal_ff <= in_nal_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         lnz_ff    <= lnz_in;
         hdr_ff    <= hdr_in;
      end
   end

endmodule

`default_nettype wire

[src/ans_cmd_fifo.sv]
`default_nettype none

module ans_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ans_pkg::cmd_type push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic             head_valid,
   output      ans_pkg::cmd_type head
);

   localparam int DEPTH = ans_pkg::CMD_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ans_pkg::cmd_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/ans_back.sv]
`default_nettype none

`include "annexb_nal_splitter_assert.svh"

module ans_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ans_pkg::cfg_type cfg,
   input  wire logic             head_valid,
   input  wire ans_pkg::cmd_type head,
   output      logic             pop,
   ans_rsp_if.source             rsp
);

   typedef struct packed {
      logic                          result_kind;
      logic [5:0]                    nal_type;
      ans_pkg::nal_class_type        nal_class;
      logic [ans_pkg::OFF_W-1:0]     nal_offset;
      logic [ans_pkg::OFF_W-1:0]     nal_length;
      logic                          is_key;
      logic [ans_pkg::SIZE_W-1:0]    unit_size;
      logic                          unit_written;
      logic [ans_pkg::TS_W-1:0]      decode_time;
      logic                          became_ready;
      logic                          last_result;
   } rsp_type;

   ans_pkg::back_state_type     state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;
   logic [2:0]                  cap_ff, cap_in;
   logic                        ready_ff, ready_in;
   logic                        key_ff, key_in;
   logic [ans_pkg::SIZE_W-1:0]  total_ff, total_in;
   logic                        base_valid_ff, base_valid_in;
   logic [ans_pkg::TS_W-1:0]    base_time_ff, base_time_in;

   logic                        act, emit_desc, emit_summ;
   ans_pkg::nal_class_type      cls;
   logic                        slice_key;
   logic [5:0]                  t;
   logic [ans_pkg::SIZE_W:0]    sum;
   logic [2:0]                  need;
   logic                        became, ready_new, wr_ok, written;
   logic [ans_pkg::TS_W-1:0]    base_sel;

   assign act = head_valid && (!rsp_valid_ff || rsp.ready);

   // FSM outputs
   always_comb begin
      emit_desc = 1'b0;
      emit_summ = 1'b0;
      pop       = 1'b0;
      unique case (state_ff)
         ans_pkg::BK_DESC: begin
            emit_desc = act && head.close_valid;
            emit_summ = act && !head.close_valid;
            pop       = act && !(head.close_valid && head.summary_valid);
         end
         ans_pkg::BK_SUMM: begin
            emit_summ = act;
            pop       = act;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ans_pkg::BK_DESC: begin
            if (act && head.close_valid && head.summary_valid) begin
               state_in = ans_pkg::BK_SUMM;
            end
         end
         ans_pkg::BK_SUMM: begin
            if (act) begin
               state_in = ans_pkg::BK_DESC;
            end
         end
         default: begin
            state_in = ans_pkg::BK_DESC;
         end
      endcase
   end

   // NAL type rules
   always_comb begin
      slice_key = 1'b0;
      cls       = ans_pkg::CLS_DROP;
      if (!cfg.codec_select) begin
         t = head.hdr_type & ans_pkg::AVC_TYPE_MASK;
      end else begin
         t = head.hdr_type & ans_pkg::HEVC_TYPE_MASK;
      end
      if (cfg.video_enable) begin
         if (!cfg.codec_select) begin
            if (t == ans_pkg::AVC_SPS) begin
               cls = ready_ff ? ans_pkg::CLS_DROP : ans_pkg::CLS_SPS;
            end else if (t == ans_pkg::AVC_PPS) begin
               cls = ready_ff ? ans_pkg::CLS_DROP : ans_pkg::CLS_PPS;
            end else if (t == ans_pkg::AVC_SEI) begin
               cls = ans_pkg::CLS_SEI;
            end else begin
               cls       = ans_pkg::CLS_SLICE;
               slice_key = t == ans_pkg::AVC_IDR;
            end
         end else begin
            if (t == ans_pkg::HEVC_VPS) begin
               cls = ready_ff ? ans_pkg::CLS_DROP : ans_pkg::CLS_VPS;
            end else if (t == ans_pkg::HEVC_SPS) begin
               cls = ready_ff ? ans_pkg::CLS_DROP : ans_pkg::CLS_SPS;
            end else if (t == ans_pkg::HEVC_PPS) begin
               cls = ready_ff ? ans_pkg::CLS_DROP : ans_pkg::CLS_PPS;
            end else if (t == ans_pkg::HEVC_SEI_PRE || t == ans_pkg::HEVC_SEI_SUF) begin
               cls = ans_pkg::CLS_SEI;
            end else if (t >= ans_pkg::HEVC_KEY_LO && t <= ans_pkg::HEVC_KEY_HI) begin
               cls       = ans_pkg::CLS_SLICE;
               slice_key = 1'b1;
            end else if (t <= ans_pkg::HEVC_SLICE_HI) begin
               cls = ans_pkg::CLS_SLICE;
            end
         end
      end
   end

   // each kept slice costs its length plus a 4-byte prefix, saturating
   assign sum = {1'b0, total_ff} + (ans_pkg::SIZE_W + 1)'(head.length)
                + (ans_pkg::SIZE_W + 1)'(4);

   assign need      = cfg.codec_select ? 3'b111 : 3'b110;
   assign became    = cfg.video_enable && !ready_ff && ((cap_ff & need) == need);
   assign ready_new = ready_ff || became;
   assign wr_ok     = cfg.video_enable && ready_new && (total_ff != '0);
   assign written   = wr_ok && (base_valid_ff || key_ff);
   assign base_sel  = base_valid_ff ? base_time_ff : head.timestamp;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_in        = rsp_ff;
      cap_in        = cap_ff;
      ready_in      = ready_ff;
      key_in        = key_ff;
      total_in      = total_ff;
      base_valid_in = base_valid_ff;
      base_time_in  = base_time_ff;
      if (emit_desc) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.nal_type    = head.hdr_type;
         rsp_in.nal_class   = cls;
         rsp_in.nal_offset  = head.offset;
         rsp_in.nal_length  = head.length;
         rsp_in.is_key      = slice_key;
         rsp_in.last_result = !head.summary_valid;
         case (cls)
            ans_pkg::CLS_VPS: cap_in = cap_ff | 3'b001;
            ans_pkg::CLS_SPS: cap_in = cap_ff | 3'b010;
            ans_pkg::CLS_PPS: begin
               cap_in = cap_ff | 3'b100;
               if (head.trim_ok) begin
                  rsp_in.nal_length = head.trim_length;
               end
            end
            ans_pkg::CLS_SLICE: begin
               total_in = (sum > (ans_pkg::SIZE_W + 1)'(ans_pkg::TOTAL_MAX)) ?
                          ans_pkg::TOTAL_MAX : sum[ans_pkg::SIZE_W-1:0];
               key_in   = key_ff || slice_key;
            end
            default: begin
               cap_in = cap_ff;
            end
         endcase
      end
      if (emit_summ) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = '0;
         rsp_in.result_kind  = 1'b1;
         rsp_in.nal_class    = ans_pkg::CLS_VPS;
         rsp_in.is_key       = key_ff;
         rsp_in.unit_size    = total_ff;
         rsp_in.unit_written = written;
         rsp_in.decode_time  = written ? head.timestamp - base_sel : '0;
         rsp_in.became_ready = became;
         rsp_in.last_result  = 1'b1;
         ready_in            = ready_new;
         if (wr_ok && !base_valid_ff && key_ff) begin
            base_valid_in = 1'b1;
            base_time_in  = head.timestamp;
         end
         key_in   = 1'b0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ans_pkg::BK_DESC;
         rsp_valid_ff  <= 1'b0;
         cap_ff        <= '0;
         ready_ff      <= 1'b0;
         key_ff        <= 1'b0;
         total_ff      <= '0;
         base_valid_ff <= 1'b0;
         base_time_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cap_ff        <= cap_in;
         ready_ff      <= ready_in;
         key_ff        <= key_in;
         total_ff      <= total_in;
         base_valid_ff <= base_valid_in;
         base_time_ff  <= base_time_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_kind  = rsp_ff.result_kind;
   assign rsp.nal_type     = rsp_ff.nal_type;
   assign rsp.nal_class    = rsp_ff.nal_class;
   assign rsp.nal_offset   = rsp_ff.nal_offset;
   assign rsp.nal_length   = rsp_ff.nal_length;
   assign rsp.is_key       = rsp_ff.is_key;
   assign rsp.unit_size    = rsp_ff.unit_size;
   assign rsp.unit_written = rsp_ff.unit_written;
   assign rsp.decode_time  = rsp_ff.decode_time;
   assign rsp.became_ready = rsp_ff.became_ready;
   assign rsp.last_result  = rsp_ff.last_result;

   `ANS_ASSERT_NEXT(a_ready_sticky, clock, reset, ready_ff, ready_ff)
   `ANS_ASSERT_NOW(a_base_needs_ready, clock, reset, base_valid_ff, ready_ff)
   `ANS_ASSERT_NEXT(a_summary_clears_total, clock, reset, emit_summ, total_ff == '0 && !key_ff)
   `ANS_ASSERT_NOW(a_summ_state_has_work, clock, reset, state_ff == ans_pkg::BK_SUMM, head_valid && head.summary_valid)

endmodule

`default_nettype wire

[src/annexb_nal_splitter.sv]
// A result is scanned into the command queue, then classified into the output
// register, and is held back while the result queue backs up.
// Throughput: one byte per cycle while the queue is not full; the last byte of a
// unit that also closes a NAL puts two results through the single output register.
// Reset (synchronous, active high) clears scan state, parameter set capture,
// readiness, base timestamp and both control registers.
`default_nettype none

module annexb_nal_splitter #(
   parameter int MAX_UNIT_BYTES = 4194304
) (
   input  wire logic clock,
   input  wire logic reset,
   ans_req_if.sink   req_chan,
   ans_rsp_if.source rsp_chan,
   ans_csr_if.sink   csr_chan
);

   localparam int LIMIT = (MAX_UNIT_BYTES < ans_pkg::POS_CAP) ?
                          MAX_UNIT_BYTES : ans_pkg::POS_CAP;
   localparam int POS_W = $clog2(LIMIT + 1);

   logic             video_enable_ff, video_enable_in;
   logic             codec_select_ff, codec_select_in;
   ans_pkg::cfg_type cfg;
   logic             q_push, q_full, q_pop, q_head_valid;
   ans_pkg::cmd_type q_data, q_head;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      video_enable_in = video_enable_ff;
      codec_select_in = codec_select_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            ans_pkg::CSR_VIDEO_ENABLE: video_enable_in = csr_chan.data;
            ans_pkg::CSR_CODEC_SELECT: codec_select_in = csr_chan.data;
            default: begin
               video_enable_in = video_enable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         video_enable_ff <= 1'b0;
         codec_select_ff <= 1'b0;
      end else begin
         video_enable_ff <= video_enable_in;
         codec_select_ff <= codec_select_in;
      end
   end

   assign cfg.video_enable = video_enable_ff;
   assign cfg.codec_select = codec_select_ff;

   ans_front #(
      .LIMIT (LIMIT),
      .POS_W (POS_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_data)
   );

   ans_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   ans_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (q_head_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire
